// ----- hdl/vgne_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Volume gradient normal encoder package
// Shared constants, types and helper functions.
// ---------------------------------------------------------------------------
package vgne_pkg;

    localparam int MaxX   = 64;
    localparam int MaxY   = 64;
    localparam int MaxZ   = 64;
    localparam int CW     = 6;                 // coordinate width
    localparam int SW     = 7;                 // size register width
    localparam int ADDR_W = 3 * CW;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [7:0]  CODE_ZERO = 8'd128;
    localparam logic [15:0] SCALE_SQ  = 16'd65025;   // 255 squared

    typedef logic signed [15:0] sum_t;

    typedef struct packed {
        sum_t       sx;
        sum_t       sy;
        sum_t       sz;
        logic [7:0] density;
    } gather_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_SQUARE,
        ST_SUM,
        ST_ENCODE,
        ST_OUTPUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        PH_RHS,
        PH_KK,
        PH_MUL,
        PH_CMP
    } enc_phase_t;

    function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] r, input logic [SW-1:0] mx);
        logic [SW-1:0] res;
        begin
            if (r == '0)
                res = SW'(1);
            else if (r > mx)
                res = mx;
            else
                res = r;
            return res;
        end
    endfunction

    function automatic logic [CW-1:0] clamp_pos(input logic [CW-1:0] p, input logic [SW-1:0] n);
        logic [SW-1:0] lim;
        begin
            lim = n - SW'(1);
            if ({1'b0, p} > lim)
                return lim[CW-1:0];
            else
                return p;
        end
    endfunction

    // Neighbour coordinate at offset o-1, held inside 0..n-1.
    function automatic logic [CW-1:0] nb_coord(input logic [CW-1:0] c, input logic [1:0] o,
                                               input logic [SW-1:0] n);
        logic [SW-1:0] up;
        begin
            up = {1'b0, c} + SW'(1);
            unique case (o)
                2'd0:    return (c == '0) ? c : c - CW'(1);
                2'd2:    return (up >= n) ? c : up[CW-1:0];
                default: return c;
            endcase
        end
    endfunction

endpackage

// ----- hdl/vgne_voxel_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Voxel store
// Single-port-write, single-port-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module vgne_voxel_ram
    import vgne_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/vgne_gather.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Neighbourhood gather
// Reads the 27 clamped neighbours of a voxel and accumulates the three
// weighted central-difference sums and the centre density.
// ---------------------------------------------------------------------------
module vgne_gather
    import vgne_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CW-1:0]     cx,
    input  logic [CW-1:0]     cy,
    input  logic [CW-1:0]     cz,
    input  logic [SW-1:0]     nx,
    input  logic [SW-1:0]     ny,
    input  logic [SW-1:0]     nz,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output gather_res_t       res,
    output logic              done
);

    logic       busy_reg;
    logic [1:0] ox_reg, oy_reg, oz_reg;
    logic       vld_d_reg, last_d_reg;
    logic [1:0] ox_d_reg, oy_d_reg, oz_d_reg;
    sum_t       sx_reg, sy_reg, sz_reg;
    logic [7:0] dens_reg;
    logic       done_reg;
    logic       last_issue;
    logic [CW-1:0] ax, ay, az;
    logic [2:0] shx, shy, shz;
    sum_t       tx, ty, tz;

    assign last_issue = (ox_reg == 2'd2) && (oy_reg == 2'd2) && (oz_reg == 2'd2);
    assign ax = nb_coord(cx, ox_reg, nx);
    assign ay = nb_coord(cy, oy_reg, ny);
    assign az = nb_coord(cz, oz_reg, nz);
    assign rd_en   = busy_reg;
    assign rd_addr = {az, ay, ax};

    // Weight 1,4,1 per axis becomes a left shift of 0 or 2.
    assign shx = ((oy_d_reg == 2'd1) ? 3'd2 : 3'd0) + ((oz_d_reg == 2'd1) ? 3'd2 : 3'd0);
    assign shy = ((ox_d_reg == 2'd1) ? 3'd2 : 3'd0) + ((oz_d_reg == 2'd1) ? 3'd2 : 3'd0);
    assign shz = ((ox_d_reg == 2'd1) ? 3'd2 : 3'd0) + ((oy_d_reg == 2'd1) ? 3'd2 : 3'd0);
    assign tx  = sum_t'({8'd0, rd_data} << shx);
    assign ty  = sum_t'({8'd0, rd_data} << shy);
    assign tz  = sum_t'({8'd0, rd_data} << shz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ox_reg     <= 2'd0;
            oy_reg     <= 2'd0;
            oz_reg     <= 2'd0;
            vld_d_reg  <= 1'b0;
            last_d_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            vld_d_reg  <= busy_reg;
            last_d_reg <= busy_reg && last_issue;
            done_reg   <= vld_d_reg && last_d_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                ox_reg   <= 2'd0;
                oy_reg   <= 2'd0;
                oz_reg   <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (last_issue)
                    busy_reg <= 1'b0;
                if (ox_reg == 2'd2)
                begin
                    ox_reg <= 2'd0;
                    if (oy_reg == 2'd2)
                    begin
                        oy_reg <= 2'd0;
                        oz_reg <= oz_reg + 2'd1;
                    end
                    else
                        oy_reg <= oy_reg + 2'd1;
                end
                else
                    ox_reg <= ox_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ox_d_reg <= ox_reg;
        oy_d_reg <= oy_reg;
        oz_d_reg <= oz_reg;
        if (start)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
        end
        else if (vld_d_reg)
        begin
            if (ox_d_reg == 2'd2)
                sx_reg <= sx_reg + tx;
            else if (ox_d_reg == 2'd0)
                sx_reg <= sx_reg - tx;
            if (oy_d_reg == 2'd2)
                sy_reg <= sy_reg + ty;
            else if (oy_d_reg == 2'd0)
                sy_reg <= sy_reg - ty;
            if (oz_d_reg == 2'd2)
                sz_reg <= sz_reg + tz;
            else if (oz_d_reg == 2'd0)
                sz_reg <= sz_reg - tz;
            if (ox_d_reg == 2'd1 && oy_d_reg == 2'd1 && oz_d_reg == 2'd1)
                dens_reg <= rd_data;
        end
    end

    assign res.sx      = sx_reg;
    assign res.sy      = sy_reg;
    assign res.sz      = sz_reg;
    assign res.density = dens_reg;
    assign done        = done_reg;

endmodule

// ----- hdl/vgne_encode.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Component encoder
// Binary search for the largest code e with (2e-256)*L <= 255*s, using
// squared integer comparisons; each bit runs the KK, MUL and CMP phases.
// ---------------------------------------------------------------------------
module vgne_encode
    import vgne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  sum_t        s,
    input  logic [26:0] sq,
    input  logic [27:0] n,
    output logic [7:0]  code,
    output logic        done
);

    enc_phase_t  phase_reg, phase_next;
    logic        busy_reg;
    logic [2:0]  bit_reg;
    logic [7:0]  code_reg;
    logic        done_reg;
    logic [43:0] rhs_reg;
    logic [15:0] kk_reg;
    logic [43:0] lhs_reg;
    logic [7:0]  cand;
    logic [8:0]  absk;
    logic        kpos;
    logic        fits;

    assign cand = code_reg | (8'd1 << bit_reg);
    assign kpos = cand > 8'd128;
    assign absk = kpos ? ({cand, 1'b0} - 9'd256) : (9'd256 - {cand, 1'b0});

    always_comb
    begin
        priority if (!kpos && !s[15])
            fits = 1'b1;
        else if (kpos && s[15])
            fits = 1'b0;
        else if (kpos)
            fits = lhs_reg <= rhs_reg;
        else
            fits = lhs_reg >= rhs_reg;
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_RHS:  phase_next = PH_KK;
            PH_KK:   phase_next = PH_MUL;
            PH_MUL:  phase_next = PH_CMP;
            PH_CMP:  phase_next = PH_KK;
            default: phase_next = PH_RHS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RHS;
            busy_reg  <= 1'b0;
            bit_reg   <= 3'd7;
            code_reg  <= 8'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_RHS;
                bit_reg   <= 3'd7;
                code_reg  <= 8'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_next;
                if (phase_reg == PH_CMP)
                begin
                    if (fits)
                        code_reg <= cand;
                    if (bit_reg == 3'd0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                        bit_reg <= bit_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && phase_reg == PH_RHS)
            rhs_reg <= 44'(SCALE_SQ) * 44'(sq);
        if (busy_reg && phase_reg == PH_KK)
            kk_reg <= absk[7:0] * absk[7:0];
        if (busy_reg && phase_reg == PH_MUL)
            lhs_reg <= 44'(kk_reg) * 44'(n);
    end

    assign code = code_reg;
    assign done = done_reg;

endmodule

// ----- hdl/volume_gradient_normal_encoder_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Volume gradient normal encoder, top level
// Loads an 8-bit volume and answers gradient-normal queries.
//
//   Channel   Direction  Carries
//   s_axis    in         load voxel or query position (tuser = mode)
//   m_axis    out        encoded normal and density, one per query
//   cfg       in         size_x/y/z register writes
//
// A load leaves ready high. A query holds ready low from acceptance
// until its result is offered, through the 27 neighbour reads over the
// single voxel RAM read port, the squares and the norm, the component
// encoders (a setup step and 8 search steps) and the hand-over, which
// waits while an earlier result is still held by a stalled output.
// The result waits in the output register while the next transaction is
// accepted. Reset clears control state only; voxel contents are undefined
// until loaded.
// ---------------------------------------------------------------------------
module volume_gradient_normal_encoder_top
    import vgne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pos_x[5:0], pos_y[11:6], pos_z[17:12], voxel_in[25:18]
    input  logic [0:0]  s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // normal_x[7:0], normal_y[15:8], normal_z[23:16], density[31:24]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    ctl_state_t    state_reg, state_next;
    logic [SW-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [SW-1:0] nx, ny, nz;
    logic [CW-1:0] px, py, pz;
    logic [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [7:0]    vin;
    logic          in_acc, is_query, load_ok;
    logic          g_start, g_done;
    logic          rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]    rd_data;
    gather_res_t   gres;
    logic [26:0]   sqx_reg, sqy_reg, sqz_reg;
    logic [27:0]   n_reg;
    logic          enc_start;
    logic [7:0]    ex, ey, ez;
    logic [2:0]    enc_done;
    logic          out_load;
    logic          m_valid_reg;
    logic [31:0]   m_data_reg;

    assign nx = eff_size(size_x_reg, SW'(MaxX));
    assign ny = eff_size(size_y_reg, SW'(MaxY));
    assign nz = eff_size(size_z_reg, SW'(MaxZ));

    assign px  = s_axis_tdata[5:0];
    assign py  = s_axis_tdata[11:6];
    assign pz  = s_axis_tdata[17:12];
    assign vin = s_axis_tdata[25:18];

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign is_query = s_axis_tuser[0] == MODE_QUERY;
    assign load_ok  = ({1'b0, px} < nx) && ({1'b0, py} < ny) && ({1'b0, pz} < nz);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SW'(MaxX);
            size_y_reg <= SW'(MaxY);
            size_z_reg <= SW'(MaxZ);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data;
                CFG_SIZE_Y: size_y_reg <= cfg_data;
                CFG_SIZE_Z: size_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Control sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc && is_query) state_next = ST_GATHER;
            ST_GATHER: if (g_done) state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ENCODE;
            ST_ENCODE: if (enc_done[0]) state_next = ST_OUTPUT;
            ST_OUTPUT: if (!m_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        g_start       = 1'b0;
        enc_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_GATHER: g_start = 1'b0;
            ST_SQUARE: ;
            ST_SUM:    enc_start = 1'b1;
            ST_ENCODE: ;
            ST_OUTPUT: out_load = !m_valid_reg || m_axis_tready;
            default:   ;
        endcase
        if (state_reg == ST_IDLE && in_acc && is_query)
            g_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (g_start)
        begin
            cx_reg <= clamp_pos(px, nx);
            cy_reg <= clamp_pos(py, ny);
            cz_reg <= clamp_pos(pz, nz);
        end
        if (state_reg == ST_SQUARE)
        begin
            sqx_reg <= 27'(32'(gres.sx) * 32'(gres.sx));
            sqy_reg <= 27'(32'(gres.sy) * 32'(gres.sy));
            sqz_reg <= 27'(32'(gres.sz) * 32'(gres.sz));
        end
        if (state_reg == ST_SUM)
            n_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg} + {1'b0, sqz_reg};
    end

    vgne_voxel_ram u_ram (
        .clk     (clk),
        .wr_en   (in_acc && !is_query && load_ok),
        .wr_addr ({pz, py, px}),
        .wr_data (vin),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The centre is held in registers, as the input bus moves on once the
    // query transaction has been accepted.
    vgne_gather u_gather (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (g_start),
        .cx      (cx_reg),
        .cy      (cy_reg),
        .cz      (cz_reg),
        .nx      (nx),
        .ny      (ny),
        .nz      (nz),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (gres),
        .done    (g_done)
    );

    vgne_encode u_enc_x (
        .clk (clk), .rst_n (rst_n), .start (enc_start),
        .s (gres.sx), .sq (sqx_reg), .n (n_reg), .code (ex), .done (enc_done[0])
    );

    vgne_encode u_enc_y (
        .clk (clk), .rst_n (rst_n), .start (enc_start),
        .s (gres.sy), .sq (sqy_reg), .n (n_reg), .code (ey), .done (enc_done[1])
    );

    vgne_encode u_enc_z (
        .clk (clk), .rst_n (rst_n), .start (enc_start),
        .s (gres.sz), .sq (sqz_reg), .n (n_reg), .code (ez), .done (enc_done[2])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (n_reg == '0)
                m_data_reg <= {gres.density, CODE_ZERO, CODE_ZERO, CODE_ZERO};
            else
                m_data_reg <= {gres.density, ez, ey, ex};
        end
    end

    // The y and z encoders finish in step with the x encoder.
    logic unused_ok;
    assign unused_ok = &{enc_done[2:1], 1'b0};

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- hdl/vgne_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
module vgne_checker
    import vgne_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == MODE_QUERY |=> !s_axis_tready)
        else $error("query did not occupy the block");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == MODE_LOAD |=> s_axis_tready)
        else $error("load stalled the input");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind volume_gradient_normal_encoder_top vgne_checker u_vgne_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Volume gradient normal encoder testbench
// Loads small volumes through the input stream and queries the smoothed
// gradient. An internal predictor keeps its own copy of the volume and the
// size registers and works out each encoded normal. Every result is
// compared field by field, in order. Both stream sides idle at random, and
// the output side is held off once for a long stretch.
// ---------------------------------------------------------------------------
module testbench;
    import vgne_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;    // index beyond the register list
    localparam int         DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [7:0] density;
        logic [7:0] nz;
        logic [7:0] ny;
        logic [7:0] nx;
    } normal_t;

    typedef struct {
        logic       mode;
        int         x;
        int         y;
        int         z;
        int         v;
        bit         typed;
        normal_t    res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;

    logic [7:0]    voxels [MaxX*MaxY*MaxZ];
    bit            loaded [MaxX*MaxY*MaxZ];
    logic [SW-1:0] size_reg [3];
    normal_t       normal_q [$];
    bit            typed_q [$];
    normal_t       typed_res_q [$];
    int            errors = 0;
    bit            quiet = 1'b0;
    bit            hold_req = 1'b0;

    volume_gradient_normal_encoder_top i_dut (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("volume_gradient_normal_encoder_top regression: fail");
        $finish;
    end

    function automatic int axis_size(input int a);
        int mx;
        begin
            mx = (a == 0) ? MaxX : (a == 1) ? MaxY : MaxZ;
            if (size_reg[a] == 0)
                return 1;
            if (size_reg[a] > mx)
                return mx;
            return size_reg[a];
        end
    endfunction

    function automatic int clip(input int p, input int n);
        begin
            if (p < 0)
                return 0;
            if (p >= n)
                return n - 1;
            return p;
        end
    endfunction

    function automatic int voxel_at(input int x, input int y, input int z);
        begin
            return voxels[(clip(z, axis_size(2)) * MaxY + clip(y, axis_size(1))) * MaxX
                          + clip(x, axis_size(0))];
        end
    endfunction

    // Largest e with (2e - 256) * |S| <= 255 * s, done on squares only.
    function automatic logic [7:0] encode_component(input longint s, input longint n);
        longint k;
        bit     ok;
        begin
            for (int e = 255; e > 0; e--)
            begin
                k = 2 * e - 256;
                if (k <= 0 && s >= 0)
                    ok = 1;
                else if (k > 0 && s < 0)
                    ok = 0;
                else if (k > 0)
                    ok = (k * k * n <= 65025 * s * s);
                else
                    ok = (k * k * n >= 65025 * s * s);
                if (ok)
                    return e[7:0];
            end
            return 8'd0;
        end
    endfunction

    function automatic normal_t gradient_normal(input int qx, input int qy, input int qz);
        int      x, y, z, sx, sy, sz, wt;
        int      wgt [3];
        longint  n;
        normal_t r;
        begin
            wgt = '{1, 4, 1};
            x = clip(qx, axis_size(0));
            y = clip(qy, axis_size(1));
            z = clip(qz, axis_size(2));
            sx = 0;
            sy = 0;
            sz = 0;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                begin
                    wt = wgt[a] * wgt[b];
                    sx += wt * (voxel_at(x + 1, y + b - 1, z + a - 1)
                                - voxel_at(x - 1, y + b - 1, z + a - 1));
                    sy += wt * (voxel_at(x + b - 1, y + 1, z + a - 1)
                                - voxel_at(x + b - 1, y - 1, z + a - 1));
                    sz += wt * (voxel_at(x + b - 1, y + a - 1, z + 1)
                                - voxel_at(x + b - 1, y + a - 1, z - 1));
                end
            n = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
            if (n == 0)
            begin
                r.nx = CODE_ZERO;
                r.ny = CODE_ZERO;
                r.nz = CODE_ZERO;
            end
            else
            begin
                r.nx = encode_component(sx, n);
                r.ny = encode_component(sy, n);
                r.nz = encode_component(sz, n);
            end
            r.density = voxel_at(x, y, z);
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        begin
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
            errors++;
        end
    endtask

    // Watch both streams; predict at input acceptance, compare at output acceptance.
    always @(posedge clk)
    begin
        int      x, y, z, idx;
        normal_t got, want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            x = s_axis_tdata[5:0];
            y = s_axis_tdata[11:6];
            z = s_axis_tdata[17:12];
            if (s_axis_tuser[0] == MODE_LOAD)
            begin
                if (x < axis_size(0) && y < axis_size(1) && z < axis_size(2))
                begin
                    idx = (z * MaxY + y) * MaxX + x;
                    voxels[idx] = s_axis_tdata[25:18];
                    loaded[idx] = 1'b1;
                end
            end
            else
                normal_q.push_back(gradient_normal(x, y, z));
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (normal_q.size() == 0)
            begin
                $display("mismatch: result with nothing expected at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = normal_q.pop_front();
                if (typed_q.size() != 0 && typed_q.pop_front())
                    want = typed_res_q.pop_front();
                if (got.nx !== want.nx)
                    report_mismatch("normal_x", got.nx, want.nx);
                if (got.ny !== want.ny)
                    report_mismatch("normal_y", got.ny, want.ny);
                if (got.nz !== want.nz)
                    report_mismatch("normal_z", got.nz, want.nz);
                if (got.density !== want.density)
                    report_mismatch("density", got.density, want.density);
            end
        end
    end

    // Output side: random stalls, plus one long hold-off when asked.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic mode, input int x, input int y, input int z,
                             input int v);
        begin
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= mode;
            s_axis_tdata  <= {6'd0, v[7:0], z[5:0], y[5:0], x[5:0]};
            forever
            begin
                @(posedge clk);
                if (s_axis_tready)
                    break;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value[6:0];
            forever
            begin
                @(posedge clk);
                if (cfg_ready)
                    break;
            end
            cfg_valid <= 1'b0;
            if (idx != CFG_UNUSED)
                size_reg[idx] = value[6:0];
        end
    endtask

    // Loads leave no result, so allow the block to finish any query in flight.
    task automatic wait_idle();
        begin
            s_axis_tvalid <= 1'b0;
            wait (normal_q.size() == 0);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic set_sizes(input int sx, input int sy, input int sz);
        begin
            write_reg(CFG_SIZE_X, sx);
            write_reg(CFG_SIZE_Y, sy);
            write_reg(CFG_SIZE_Z, sz);
        end
    endtask

    function automatic stim_row_t row(input logic mode, input int x, input int y, input int z,
                                      input int v, input bit typed = 0, input int ex = 0,
                                      input int ey = 0, input int ez = 0, input int ed = 0);
        stim_row_t r;
        begin
            r.mode = mode;
            r.x = x;
            r.y = y;
            r.z = z;
            r.v = v;
            r.typed = typed;
            r.res = {ed[7:0], ez[7:0], ey[7:0], ex[7:0]};
            return r;
        end
    endfunction

    initial
    begin
        stim_row_t directed [$];
        int        sizes [][3];
        int        nx, ny, nz, idx;

        for (int a = 0; a < 3; a++)
            size_reg[a] = 7'd64;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A two-voxel line along x: flat, rising, falling, and loads outside the box.
        set_sizes(2, 1, 1);
        write_reg(CFG_UNUSED, 5);
        directed.push_back(row(MODE_LOAD,  0, 0, 0, 200));
        directed.push_back(row(MODE_LOAD,  1, 0, 0, 200));
        directed.push_back(row(MODE_QUERY, 0, 0, 0, 0, 1, 128, 128, 128, 200));
        directed.push_back(row(MODE_LOAD,  0, 0, 0, 0));
        directed.push_back(row(MODE_LOAD,  1, 0, 0, 255));
        directed.push_back(row(MODE_QUERY, 0, 0, 0, 255, 1, 255, 128, 128, 0));
        directed.push_back(row(MODE_QUERY, 63, 63, 63, 0, 1, 255, 128, 128, 255));
        directed.push_back(row(MODE_LOAD,  0, 0, 0, 255));
        directed.push_back(row(MODE_LOAD,  1, 0, 0, 0));
        directed.push_back(row(MODE_QUERY, 0, 0, 0, 0, 1, 0, 128, 128, 255));
        directed.push_back(row(MODE_LOAD,  2, 0, 0, 77));
        directed.push_back(row(MODE_LOAD,  0, 63, 0, 77));
        directed.push_back(row(MODE_LOAD,  63, 63, 63, 255));
        directed.push_back(row(MODE_QUERY, 0, 0, 0, 0, 1, 0, 128, 128, 255));
        directed.push_back(row(MODE_QUERY, 1, 0, 63, 170));
        foreach (directed[i])
        begin
            if (directed[i].mode == MODE_QUERY)
            begin
                typed_q.push_back(directed[i].typed);
                if (directed[i].typed)
                    typed_res_q.push_back(directed[i].res);
            end
            send_item(directed[i].mode, directed[i].x, directed[i].y, directed[i].z,
                      directed[i].v);
        end
        wait_idle();

        sizes = '{'{4, 4, 4}, '{64, 1, 1}, '{1, 64, 1}, '{1, 1, 64}, '{0, 127, 3},
                  '{5, 3, 2}, '{1, 1, 1}, '{7, 6, 5}};
        foreach (sizes[p])
        begin
            set_sizes(sizes[p][0], sizes[p][1], sizes[p][2]);
            nx = axis_size(0);
            ny = axis_size(1);
            nz = axis_size(2);
            if (p == 2)
                hold_req = 1'b1;
            if (p == sizes.size() - 1)
                quiet = 1'b1;
            for (int z = 0; z < nz; z++)
                for (int y = 0; y < ny; y++)
                    for (int x = 0; x < nx; x++)
                    begin
                        idx = (z * MaxY + y) * MaxX + x;
                        if (!loaded[idx])
                            send_item(MODE_LOAD, x, y, z, $urandom_range(0, 255));
                    end
            repeat (48)
            begin
                case ($urandom_range(0, 9))
                    0:
                        send_item(MODE_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 63), $urandom_range(0, 255));
                    1, 2, 3:
                        send_item(MODE_LOAD, $urandom_range(0, nx - 1),
                                  $urandom_range(0, ny - 1), $urandom_range(0, nz - 1),
                                  $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                       : 255 * $urandom_range(0, 1));
                    4:
                        send_item(MODE_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 63), $urandom_range(0, 255));
                    default:
                        send_item(MODE_QUERY, $urandom_range(0, nx - 1),
                                  $urandom_range(0, ny - 1), $urandom_range(0, nz - 1),
                                  $urandom_range(0, 255));
                endcase
            end
            wait_idle();
        end

        if (errors == 0)
            $display("volume_gradient_normal_encoder_top regression: pass");
        else
            $display("volume_gradient_normal_encoder_top regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/vgne_pkg.sv
hdl/vgne_voxel_ram.sv
hdl/vgne_gather.sv
hdl/vgne_encode.sv
hdl/volume_gradient_normal_encoder_top.sv
hdl/vgne_checker.sv
tb/testbench.sv
